FILE: src/whv_pkg.sv
// ----------------------------------------------------------------------------
// whv_pkg
// Shared types and constants for the WAV header validator: chunk tags,
// status codes and the command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package whv_pkg;

  // Canonical header length in bytes
  localparam int unsigned HDR_LEN = 44;

  // Chunk tags, as they read in file order
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666d_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  // fmt chunk expectations
  localparam logic [31:0] FMT_SIZE_PCM = 32'd16;
  localparam logic [15:0] FMT_CODE_PCM = 16'd1;

  // Result status codes
  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ST_SHORT_HDR  = 4'd1;
  localparam logic [3:0] ST_RIFF       = 4'd2;
  localparam logic [3:0] ST_WAVE       = 4'd3;
  localparam logic [3:0] ST_FMT_ID     = 4'd4;
  localparam logic [3:0] ST_FMT_SIZE   = 4'd5;
  localparam logic [3:0] ST_FORMAT     = 4'd6;
  localparam logic [3:0] ST_RATE       = 4'd7;
  localparam logic [3:0] ST_ALIGN      = 4'd8;
  localparam logic [3:0] ST_DATA_ID    = 4'd9;
  localparam logic [3:0] ST_SHORT_DATA = 4'd10;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // store the accepted byte and advance the count
    logic chk12;    // RIFF / WAVE tag checks
    logic mul1;     // rate * channels, channels * bytes per sample
    logic mul2;     // times bytes per sample
    logic chk36;    // fmt chunk checks
    logic chk44;    // data tag check
    logic emit;     // load the result register and start a new buffer
  } whv_cmd_t;

  // Datapath to controller: where the next accepted byte lands
  typedef struct packed {
    logic next_is12;
    logic next_is36;
    logic next_is44;
  } whv_stat_t;

endpackage

FILE: src/whv_ctrl.sv
// ----------------------------------------------------------------------------
// whv_ctrl
// Sequencer for the WAV header validator. Takes bytes in RUN, steps through
// the check and multiply states at chunk boundaries, and owns result valid.
// ----------------------------------------------------------------------------
module whv_ctrl
  import whv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  input  logic      last_byte,
  output logic      byte_stall,
  output logic      result_valid,
  input  logic      result_stall,
  input  whv_stat_t stat,
  output whv_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_RUN,
    S_CHK12,
    S_MUL1,
    S_MUL2,
    S_CHK36,
    S_CHK44,
    S_OUT
  } state_t;

  state_t state;
  logic   last_pend;
  logic   out_busy;
  logic   out_free;
  logic   accept;

  // Handshake decode; the result register parts the byte side from result_stall
  assign out_busy   = result_valid && result_stall;
  assign out_free   = !out_busy;
  assign byte_stall = (state != S_RUN);
  assign accept     = byte_valid && !byte_stall;

  // Commands to the datapath
  always_comb begin
    cmd         = '0;
    cmd.capture = accept;
    cmd.chk12   = (state == S_CHK12);
    cmd.mul1    = (state == S_MUL1);
    cmd.mul2    = (state == S_MUL2);
    cmd.chk36   = (state == S_CHK36);
    cmd.chk44   = (state == S_CHK44);
    cmd.emit    = (state == S_OUT) && out_free;
  end

  // State and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_RUN;
      last_pend    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_RUN: begin
          if (accept) begin
            last_pend <= last_byte;
            priority if (stat.next_is12) begin
              state <= S_CHK12;
            end else if (stat.next_is36) begin
              state <= S_MUL1;
            end else if (stat.next_is44) begin
              state <= S_CHK44;
            end else if (last_byte) begin
              state <= S_OUT;
            end else begin
              state <= S_RUN;
            end
          end
        end
        S_CHK12, S_CHK36, S_CHK44: begin
          state <= last_pend ? S_OUT : S_RUN;
        end
        S_MUL1: begin
          state <= S_MUL2;
        end
        S_MUL2: begin
          state <= S_CHK36;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_RUN;
          end
        end
        default: begin
          state <= S_RUN;
        end
      endcase
    end
  end

endmodule

FILE: src/whv_datapath.sv
// ----------------------------------------------------------------------------
// whv_datapath
// Byte counter, header field registers, the byte rate multiplier, the
// sticky error code and the result register.
// ----------------------------------------------------------------------------
module whv_datapath
  import whv_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  whv_cmd_t    cmd,
  output whv_stat_t   stat,
  input  logic [7:0]  data_byte,
  output logic [3:0]  status,
  output logic [15:0] chan_count,
  output logic [31:0] samp_rate,
  output logic [15:0] samp_bits,
  output logic [31:0] data_size
);

  localparam logic [COUNT_WIDTH-1:0] POS_12  = COUNT_WIDTH'(12);
  localparam logic [COUNT_WIDTH-1:0] POS_36  = COUNT_WIDTH'(36);
  localparam logic [COUNT_WIDTH-1:0] POS_HDR = COUNT_WIDTH'(HDR_LEN);

  logic [COUNT_WIDTH-1:0] byte_position;
  logic [COUNT_WIDTH-1:0] pos_next;
  logic [3:0]             error_code;

  // Header fields; tags shift in big-endian, numbers little-endian
  logic [31:0] riff_tag;
  logic [31:0] wave_tag;
  logic [31:0] fmt_tag;
  logic [31:0] fmt_size;
  logic [15:0] fmt_code;
  logic [15:0] fld_channels;
  logic [31:0] fld_rate;
  logic [31:0] fld_avg_rate;
  logic [15:0] fld_align;
  logic [15:0] fld_bits;
  logic [31:0] data_tag;
  logic [31:0] fld_dsize;

  // Multiplier results
  logic [31:0] rate_chan;
  logic [31:0] rate_product;
  logic [31:0] align_product;
  logic [12:0] samp_bytes;

  logic [5:0]             idx;
  logic                   cap;
  logic                   ge36;
  logic                   ge44;
  logic [COUNT_WIDTH-1:0] tail;
  logic [3:0]             status_next;

  // Saturating count of the byte being accepted
  assign pos_next = (&byte_position) ? byte_position : byte_position + 1'b1;

  assign stat.next_is12 = (pos_next == POS_12);
  assign stat.next_is36 = (pos_next == POS_36);
  assign stat.next_is44 = (pos_next == POS_HDR);

  assign idx        = byte_position[5:0];
  assign cap        = cmd.capture && (byte_position < POS_HDR);
  assign samp_bytes = fld_bits[15:3];

  // Final status
  assign ge36 = (byte_position >= POS_36);
  assign ge44 = (byte_position >= POS_HDR);
  assign tail = byte_position - POS_HDR;

  always_comb begin
    priority if (error_code != ST_OK) begin
      status_next = error_code;
    end else if (!ge44) begin
      status_next = ST_SHORT_HDR;
    end else if (fld_dsize > 32'(tail)) begin
      status_next = ST_SHORT_DATA;
    end else begin
      status_next = ST_OK;
    end
  end

  // Counter and sticky error
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      error_code    <= ST_OK;
    end else if (cmd.emit) begin
      byte_position <= '0;
      error_code    <= ST_OK;
    end else begin
      if (cmd.capture) begin
        byte_position <= pos_next;
      end
      if (error_code == ST_OK) begin
        if (cmd.chk12) begin
          priority if (riff_tag != TAG_RIFF) begin
            error_code <= ST_RIFF;
          end else if (wave_tag != TAG_WAVE) begin
            error_code <= ST_WAVE;
          end else begin
            error_code <= ST_OK;
          end
        end
        if (cmd.chk36) begin
          priority if (fmt_tag != TAG_FMT) begin
            error_code <= ST_FMT_ID;
          end else if (fmt_size != FMT_SIZE_PCM) begin
            error_code <= ST_FMT_SIZE;
          end else if (fmt_code != FMT_CODE_PCM) begin
            error_code <= ST_FORMAT;
          end else if (fld_avg_rate != rate_product) begin
            error_code <= ST_RATE;
          end else if ({16'd0, fld_align} != align_product) begin
            error_code <= ST_ALIGN;
          end else begin
            error_code <= ST_OK;
          end
        end
        if (cmd.chk44 && (data_tag != TAG_DATA)) begin
          error_code <= ST_DATA_ID;
        end
      end
    end
  end

  // Header field capture by byte index
  always_ff @(posedge clk) begin
    if (cap && idx <= 6'd3) begin
      riff_tag <= {riff_tag[23:0], data_byte};
    end
    if (cap && idx >= 6'd8 && idx <= 6'd11) begin
      wave_tag <= {wave_tag[23:0], data_byte};
    end
    if (cap && idx >= 6'd12 && idx <= 6'd15) begin
      fmt_tag <= {fmt_tag[23:0], data_byte};
    end
    if (cap && idx >= 6'd16 && idx <= 6'd19) begin
      fmt_size <= {data_byte, fmt_size[31:8]};
    end
    if (cap && idx >= 6'd20 && idx <= 6'd21) begin
      fmt_code <= {data_byte, fmt_code[15:8]};
    end
    if (cap && idx >= 6'd22 && idx <= 6'd23) begin
      fld_channels <= {data_byte, fld_channels[15:8]};
    end
    if (cap && idx >= 6'd24 && idx <= 6'd27) begin
      fld_rate <= {data_byte, fld_rate[31:8]};
    end
    if (cap && idx >= 6'd28 && idx <= 6'd31) begin
      fld_avg_rate <= {data_byte, fld_avg_rate[31:8]};
    end
    if (cap && idx >= 6'd32 && idx <= 6'd33) begin
      fld_align <= {data_byte, fld_align[15:8]};
    end
    if (cap && idx >= 6'd34 && idx <= 6'd35) begin
      fld_bits <= {data_byte, fld_bits[15:8]};
    end
    if (cap && idx >= 6'd36 && idx <= 6'd39) begin
      data_tag <= {data_tag[23:0], data_byte};
    end
    if (cap && idx >= 6'd40 && idx <= 6'd43) begin
      fld_dsize <= {data_byte, fld_dsize[31:8]};
    end
  end

  // Byte rate and block align products; mul1 forms rate * channels and block align, mul2 the byte rate
  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      rate_chan     <= 32'(fld_rate * 32'(fld_channels));
      align_product <= 32'(fld_channels * 29'(samp_bytes));
    end
    if (cmd.mul2) begin
      rate_product <= 32'(rate_chan * 32'(samp_bytes));
    end
  end

  // Result register; fmt fields read as zero until byte 36 is in, data_size until byte 44
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status     <= status_next;
      chan_count <= ge36 ? fld_channels : 16'd0;
      samp_rate  <= ge36 ? fld_rate : 32'd0;
      samp_bits  <= ge36 ? fld_bits : 16'd0;
      data_size  <= ge44 ? fld_dsize : 32'd0;
    end
  end

endmodule

FILE: src/wav_header_validator.sv
// ----------------------------------------------------------------------------
// wav_header_validator
// Parses and checks the canonical 44-byte PCM WAV header of a byte stream and
// reports status and format fields once per buffer, on its last byte.
//
//   channel  signals                              direction  width
//   byte     byte_valid byte_stall data_byte      in         8 + 1
//            last_byte
//   result   result_valid result_stall status     out        4+16+32+16+32
//            chan_count samp_rate
//            samp_bits data_size
//
// One byte per cycle while byte_stall is low. Bytes 12 and 44 stall the input
// for a tag check, byte 36 for two multiplier stages for the byte rate and
// then the fmt checks. The last byte of a buffer stalls it to load the result
// register, and longer while an earlier result still waits under result_stall.
// Reset is synchronous; the block comes up ready for the first byte.
// Bytes stall only at those points; result_stall alone never stalls them.
// ----------------------------------------------------------------------------
module wav_header_validator
  import whv_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [3:0]  status,
  output logic [15:0] chan_count,
  output logic [31:0] samp_rate,
  output logic [15:0] samp_bits,
  output logic [31:0] data_size
);

  whv_cmd_t  cmd;
  whv_stat_t stat;

  whv_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .last_byte    (last_byte),
    .byte_stall   (byte_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  whv_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .data_byte  (data_byte),
    .status     (status),
    .chan_count (chan_count),
    .samp_rate  (samp_rate),
    .samp_bits  (samp_bits),
    .data_size  (data_size)
  );

`ifndef NO_ASSERTIONS
  // Status codes stay within the defined set
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (status <= ST_SHORT_DATA))
    else $error("status code out of range");

  // A last byte always holds off the next byte while the result is formed
  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    (byte_valid && !byte_stall && last_byte) |=> byte_stall)
    else $error("byte accepted right after a last byte");

  // A new result only appears once the block is busy finishing a buffer
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(byte_stall))
    else $error("result raised while bytes were flowing");
`endif

endmodule
